### sv/zigzag_scan_buffer_defines.svh
// Assertion macros shared by the zigzag scan buffer.
// Expects signals named clock and reset in the module that expands them.
`ifndef ZIGZAG_SCAN_BUFFER_DEFINES_SVH
`define ZIGZAG_SCAN_BUFFER_DEFINES_SVH

// Condition must never hold outside reset.
`define ZZSB_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("zzsb: forbidden condition seen");

// Antecedent must be followed by the consequent in the same cycle.
`define ZZSB_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zzsb: implication violated");

`endif

### sv/zzsb_pkg.sv
// Shared types and constants of the zigzag scan buffer.
// No dependencies; imported by every module of the block.
package zzsb_pkg;

   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROWS = 2'd0,
      CSR_COLS = 2'd1
   } csr_index_type;

   // One classified command on its way from front to back.
   typedef struct packed {
      logic               is_read;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               diag_end;
      logic               last;
   } cmd_meta_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               diag_end;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

### sv/zzsb_fifo.sv
// Small synchronous queue used between the parts of the zigzag scan buffer.
// Depends on zzsb_pkg for its depth and status type.
module zzsb_fifo import zzsb_pkg::*; #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCOUNT_W-1:0] count_ff;
   logic                do_push;
   logic                do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/zzsb_front.sv
// Front of the zigzag scan buffer: dimension registers, fill and scan pointers.
// Classifies each command into address plus metadata; depends on zzsb_pkg.
module zzsb_front import zzsb_pkg::*; #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16,
   parameter int AW       = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_command,
   input  logic [VALUE_W-1:0]     req_write_value,
   input  logic                   cmd_full,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   cmd_push,
   output cmd_meta_type           cmd_entry,
   output logic [AW-1:0]          cmd_addr
);

   localparam int MAXD      = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DW        = $clog2(MAXD + 1);
   localparam int ROW_RESET = (MAX_ROWS < 8) ? MAX_ROWS : 8;
   localparam int COL_RESET = (MAX_COLS < 8) ? MAX_COLS : 8;

   logic [DW-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [DW-1:0] fill_row_ff, fill_row_in, fill_col_ff, fill_col_in;
   logic [DW-1:0] llr_ff, llr_in, llc_ff, llc_in;
   logic [DW-1:0] urr_ff, urr_in, urc_ff, urc_in;
   logic [DW-1:0] cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic          up_ff, up_in;
   logic [DW-1:0] last_row, last_col;
   logic          is_last, diag_end, restart_scan, accept;

   function automatic logic [DW-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                               input int maxv);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (int'(v) > maxv) begin
         r = DW'(maxv);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] r,
                                             input logic [DW-1:0] c);
      return AW'(int'(r) * MAX_COLS + int'(c));
   endfunction

   assign last_row = rows_ff - 1'b1;
   assign last_col = cols_ff - 1'b1;
   assign accept   = req_push && !cmd_full;
   assign is_last  = (cur_row_ff == last_row) && (cur_col_ff == last_col);
   assign diag_end = up_ff ? ((cur_row_ff == urr_ff) && (cur_col_ff == urc_ff))
                           : ((cur_row_ff == llr_ff) && (cur_col_ff == llc_ff));

   assign cmd_push           = accept;
   assign cmd_entry.is_read  = req_command;
   assign cmd_entry.value    = req_write_value;
   assign cmd_entry.row      = INDEX_W'(cur_row_ff);
   assign cmd_entry.col      = INDEX_W'(cur_col_ff);
   assign cmd_entry.diag_end = diag_end;
   assign cmd_entry.last     = is_last;
   assign cmd_addr = req_command ? addr_of(cur_row_ff, cur_col_ff)
                                 : addr_of(fill_row_ff, fill_col_ff);

   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      fill_row_in  = fill_row_ff;
      fill_col_in  = fill_col_ff;
      llr_in       = llr_ff;
      llc_in       = llc_ff;
      urr_in       = urr_ff;
      urc_in       = urc_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      up_in        = up_ff;
      restart_scan = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = clamp_dim(csr_write_data, MAX_ROWS);
            CSR_COLS: cols_in = clamp_dim(csr_write_data, MAX_COLS);
            default:  ;
         endcase
         if (csr_index == CSR_ROWS || csr_index == CSR_COLS) begin
            fill_row_in  = '0;
            fill_col_in  = '0;
            restart_scan = 1'b1;
         end
      end else if (accept && !req_command) begin
         // advance the raster fill pointer
         if (fill_col_ff >= last_col) begin
            fill_col_in = '0;
            fill_row_in = (fill_row_ff >= last_row) ? '0 : fill_row_ff + 1'b1;
         end else begin
            fill_col_in = fill_col_ff + 1'b1;
         end
      end else if (accept) begin
         if (is_last) begin
            restart_scan = 1'b1;
         end else if (diag_end) begin
            // move both diagonal ends, then flip direction
            if (llr_ff >= last_row) llc_in = llc_ff + 1'b1;
            else                    llr_in = llr_ff + 1'b1;
            if (urc_ff >= last_col) urr_in = urr_ff + 1'b1;
            else                    urc_in = urc_ff + 1'b1;
            up_in = !up_ff;
            if (up_in) begin
               cur_row_in = llr_in;
               cur_col_in = llc_in;
            end else begin
               cur_row_in = urr_in;
               cur_col_in = urc_in;
            end
            if (llc_in > last_col || urr_in > last_row) restart_scan = 1'b1;
         end else if (up_ff) begin
            if (cur_row_ff == '0 || cur_col_ff >= last_col) begin
               restart_scan = 1'b1;
            end else begin
               cur_row_in = cur_row_ff - 1'b1;
               cur_col_in = cur_col_ff + 1'b1;
            end
         end else begin
            if (cur_col_ff == '0 || cur_row_ff >= last_row) begin
               restart_scan = 1'b1;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
               cur_col_in = cur_col_ff - 1'b1;
            end
         end
      end
      if (restart_scan) begin
         llr_in     = '0;
         llc_in     = '0;
         urr_in     = '0;
         urc_in     = '0;
         cur_row_in = '0;
         cur_col_in = '0;
         up_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= DW'(ROW_RESET);
         cols_ff     <= DW'(COL_RESET);
         fill_row_ff <= '0;
         fill_col_ff <= '0;
         llr_ff      <= '0;
         llc_ff      <= '0;
         urr_ff      <= '0;
         urc_ff      <= '0;
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         up_ff       <= 1'b1;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         fill_row_ff <= fill_row_in;
         fill_col_ff <= fill_col_in;
         llr_ff      <= llr_in;
         llc_ff      <= llc_in;
         urr_ff      <= urr_in;
         urc_ff      <= urc_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         up_ff       <= up_in;
      end
   end

endmodule

### sv/zzsb_back.sv
// Back of the zigzag scan buffer: matrix memory with registered read.
// Drains the command queue and feeds the result queue; depends on zzsb_pkg.
module zzsb_back import zzsb_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type cmd_status,
   input  cmd_meta_type     cmd_entry,
   input  logic [AW-1:0]    cmd_addr,
   output logic             cmd_pop,
   input  queue_status_type rsp_status,
   output logic             rsp_push,
   output rsp_type          rsp_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   cmd_meta_type       meta_ff;
   logic               pend_ff;
   logic               issue_read, issue_write;

   // hold a read back unless the result queue has room for it and the one in flight
   assign issue_read  = !cmd_status.empty && cmd_entry.is_read &&
                        ((int'(rsp_status.count) + int'(pend_ff)) < QUEUE_DEPTH);
   assign issue_write = !cmd_status.empty && !cmd_entry.is_read;
   assign cmd_pop     = issue_read || issue_write;

   always_ff @(posedge clock) begin
      if (issue_write) begin
         mem[cmd_addr] <= cmd_entry.value;
      end
      if (issue_read) begin
         rd_data_ff <= mem[cmd_addr];
         meta_ff    <= cmd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue_read;
      end
   end

   assign rsp_push          = pend_ff;
   assign rsp_data.value    = rd_data_ff;
   assign rsp_data.row      = meta_ff.row;
   assign rsp_data.col      = meta_ff.col;
   assign rsp_data.diag_end = meta_ff.diag_end;
   assign rsp_data.last     = meta_ff.last;

endmodule

### sv/zigzag_scan_buffer.sv
// Zigzag scan buffer top level: front, command queue, memory back, result queue.
// One command per cycle, bound by the single memory port, unless a read waits for room
// in the result queue; a read result reaches the rsp_ ports through the registered read
// and the result queue, writes produce nothing. Synchronous reset clears pointers and queues,
// sets each dimension to min(8, its maximum); matrix contents are not cleared, undefined until written.
`include "zigzag_scan_buffer_defines.svh"

module zigzag_scan_buffer import zzsb_pkg::*; #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_write_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [INDEX_W-1:0]        rsp_row_index,
   output logic [INDEX_W-1:0]        rsp_col_index,
   output logic                      rsp_diagonal_end,
   output logic                      rsp_scan_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int META_W = $bits(cmd_meta_type);
   localparam int CMD_W  = META_W + AW;
   localparam int RSP_W  = $bits(rsp_type);

   queue_status_type cmd_status, rsp_status;
   cmd_meta_type     front_entry, back_entry;
   logic [AW-1:0]    front_addr;
   logic [CMD_W-1:0] cmd_head;
   logic             cmd_push, cmd_pop, rsp_push;
   rsp_type          back_rsp, rsp_head;
   logic [RSP_W-1:0] rsp_word;

   assign csr_ready = 1'b1;

   zzsb_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .AW       (AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_command     (req_command),
      .req_write_value (req_write_value),
      .cmd_full        (cmd_status.full),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd_push        (cmd_push),
      .cmd_entry       (front_entry),
      .cmd_addr        (front_addr)
   );

   zzsb_fifo #(.WIDTH (CMD_W)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({front_addr, front_entry}),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .status    (cmd_status)
   );

   assign back_entry = cmd_head[META_W-1:0];

   zzsb_back #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_status (cmd_status),
      .cmd_entry  (back_entry),
      .cmd_addr   (cmd_head[CMD_W-1:META_W]),
      .cmd_pop    (cmd_pop),
      .rsp_status (rsp_status),
      .rsp_push   (rsp_push),
      .rsp_data   (back_rsp)
   );

   zzsb_fifo #(.WIDTH (RSP_W)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .pop       (rsp_pop),
      .pop_data  (rsp_word),
      .status    (rsp_status)
   );

   assign rsp_head         = rsp_word;
   assign req_full         = cmd_status.full;
   assign rsp_empty        = rsp_status.empty;
   assign rsp_read_value   = $signed(rsp_head.value);
   assign rsp_row_index    = rsp_head.row;
   assign rsp_col_index    = rsp_head.col;
   assign rsp_diagonal_end = rsp_head.diag_end;
   assign rsp_scan_last    = rsp_head.last;

   `ZZSB_ASSERT_NEVER(a_rsp_no_overflow, rsp_push && rsp_status.full)
   `ZZSB_ASSERT_NEVER(a_rsp_credit, (int'(rsp_status.count) + int'(rsp_push)) > QUEUE_DEPTH)
   `ZZSB_ASSERT_IMPLIES(a_cmd_pop_nonempty, cmd_pop, !cmd_status.empty)

endmodule
